FILE: hdl/lpd_pkg.sv
// Shared types, constants and helpers of the length-prefixed packet deframer.
`timescale 1ns / 1ps
package lpd_pkg;

  // Widths fixed by the register map and stream fields
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned FMT_W        = 2;
  localparam int unsigned HDR_LEN_W    = 4;
  localparam int unsigned LEN_W        = 32;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 4;
  localparam int unsigned USER_W       = 2;
  localparam int unsigned DEF_MAX_HDR  = 8;
  localparam int unsigned LE_MAX_BYTES = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_FORMAT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES  = 1'b1;

  // Reset values of the registers
  localparam logic [HDR_LEN_W-1:0] HDR_BYTES_RST = 4'd2;

  // Length header formats
  typedef enum logic [FMT_W-1:0] {
    FMT_BIN_TOTAL  = 2'd0,
    FMT_HEX_TOTAL  = 2'd1,
    FMT_BE_PAYLOAD = 2'd2,
    FMT_LE_PAYLOAD = 2'd3
  } len_fmt_t;

  // Live configuration
  typedef struct packed {
    len_fmt_t               fmt;
    logic [HDR_LEN_W-1:0]   hdr_bytes;
  } lpd_cfg_t;

  // Per-byte framing marks
  typedef struct packed {
    logic err;
    logic last;
    logic start;
  } lpd_mark_t;

  // Decode one ASCII hex digit; bit 4 flags a valid digit
  function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage

FILE: hdl/length_prefixed_packet_deframer_top.sv
// Top level of the length-prefixed packet deframer: stream registers and config.
`timescale 1ns / 1ps
// Each input byte comes out once, unchanged; a new byte is taken while the
// last is still in flight: a byte sits in the input register, the framer
// decides its marks in one pass and it moves into the output register,
// which drives out_tvalid. While a result waits in the output register the
// input register still takes one byte; once both hold a byte, in_tready
// stays low until out_tready frees the output. out_tlast marks the last
// byte of a packet or an aborted header; out_tuser carries packet_start
// and frame_error. Write the registers only while no byte is in flight.
module length_prefixed_packet_deframer_top import lpd_pkg::*; #(
  parameter int unsigned MAX_HEADER_BYTES = DEF_MAX_HDR
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] data_byte
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [BYTE_W-1:0]     out_tdata,  // [7:0] out_byte
  output logic                  out_tlast,  // packet_end
  output logic [USER_W-1:0]     out_tuser,  // [0] packet_start, [1] frame_error
  // Register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  lpd_cfg_t             cfg_r;
  logic                 in_v_r;
  logic [BYTE_W-1:0]    in_byte_r;
  logic                 out_v_r;
  logic [BYTE_W-1:0]    out_byte_r;
  lpd_mark_t            out_mark_r;
  lpd_mark_t            mark;
  logic                 move;

  assign cfg_ready = 1'b1;

  // Hold register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fmt       <= FMT_BIN_TOTAL;
      cfg_r.hdr_bytes <= HDR_BYTES_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LENGTH_FORMAT: cfg_r.fmt       <= len_fmt_t'(cfg_data[FMT_W-1:0]);
        REG_HEADER_BYTES:  cfg_r.hdr_bytes <= cfg_data[HDR_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Move a byte from input to output register when the output frees up
  assign move      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || move;

  lpd_framer #(
    .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
  ) u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (move),
    .byte_in (in_byte_r),
    .cfg     (cfg_r),
    .mark    (mark)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) in_v_r <= 1'b0;
    else if (in_tready) in_v_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_byte_r <= in_tdata;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (move) out_v_r <= 1'b1;
    else if (out_tready) out_v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte_r <= in_byte_r;
      out_mark_r <= mark;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_mark_r.last;
  assign out_tuser  = {out_mark_r.err, out_mark_r.start};

  // A framing error always closes the packet
  a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_mark_r.err |-> out_mark_r.last)
    else $error("frame error without packet end");

  // A byte waiting in the input register is not lost while the output stalls
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !move |=> in_v_r && $stable(in_byte_r))
    else $error("input byte dropped during stall");

  // A stalled result is not replaced
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |=> out_v_r && $stable(out_byte_r))
    else $error("pending result overwritten");

endmodule

FILE: hdl/lpd_framer.sv
// Framing state machine: header length decode, body countdown and per-byte marks.
`timescale 1ns / 1ps
module lpd_framer import lpd_pkg::*; #(
  parameter int unsigned MAX_HEADER_BYTES = DEF_MAX_HDR
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [BYTE_W-1:0] byte_in,
  input  lpd_cfg_t          cfg,
  output lpd_mark_t         mark
);

  logic                 in_body_r, in_body_nxt;
  logic [HDR_LEN_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [LEN_W-1:0]     acc_r, acc_nxt;
  logic                 hex_stop_r, hex_stop_nxt;
  logic [LEN_W-1:0]     remain_r, remain_nxt;

  logic [LEN_W-1:0]     acc_base, acc_upd, hb32;
  logic                 hs_base, hs_upd;
  logic [4:0]           hex_d;
  logic                 hdr_bad, last_hdr, bin_ok, payload_fmt;
  logic [LEN_W:0]       pay_sum;
  logic                 len_err, len_eq;
  logic [LEN_W-1:0]     body_len;

  assign hex_d       = hex_digit(byte_in);
  assign hb32        = LEN_W'(cfg.hdr_bytes);
  assign hdr_bad     = (cfg.hdr_bytes == '0) ||
                       (cfg.hdr_bytes > HDR_LEN_W'(MAX_HEADER_BYTES));
  assign last_hdr    = ({1'b0, hdr_cnt_r} + 5'd1) >= {1'b0, cfg.hdr_bytes};
  assign bin_ok      = (cfg.hdr_bytes == 4'd2) || (cfg.hdr_bytes == 4'd4);
  assign payload_fmt = (cfg.fmt == FMT_BE_PAYLOAD) || (cfg.fmt == FMT_LE_PAYLOAD);

  // Accumulate one header byte
  always_comb begin
    acc_base = (hdr_cnt_r == '0) ? '0 : acc_r;
    hs_base  = (hdr_cnt_r == '0) ? 1'b0 : hex_stop_r;
    acc_upd  = acc_base;
    hs_upd   = hs_base;
    case (cfg.fmt)
      FMT_HEX_TOTAL: begin
        if (hs_base || !hex_d[4]) hs_upd = 1'b1;
        else acc_upd = {acc_base[LEN_W-5:0], hex_d[3:0]};
      end
      FMT_LE_PAYLOAD: begin
        if (hdr_cnt_r < HDR_LEN_W'(LE_MAX_BYTES))
          acc_upd = acc_base | (LEN_W'(byte_in) << {hdr_cnt_r[1:0], 3'b000});
      end
      default: acc_upd = {acc_base[LEN_W-BYTE_W-1:0], byte_in};
    endcase
  end

  // Check the decoded length against the header size
  always_comb begin
    pay_sum  = {1'b0, acc_upd} + {1'b0, hb32};
    len_err  = 1'b0;
    len_eq   = 1'b0;
    body_len = acc_upd - hb32;
    if (cfg.fmt != FMT_HEX_TOTAL && !bin_ok) begin
      len_err = 1'b1;
    end else if (payload_fmt) begin
      // total = payload + header wraps below the header exactly on carry out
      len_err  = pay_sum[LEN_W];
      len_eq   = (acc_upd == '0);
      body_len = acc_upd;
    end else begin
      len_err = (acc_upd == '0) || (acc_upd < hb32);
      len_eq  = (acc_upd == hb32);
    end
  end

  // Next state and marks
  always_comb begin
    in_body_nxt  = in_body_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    acc_nxt      = acc_r;
    hex_stop_nxt = hex_stop_r;
    remain_nxt   = remain_r;
    mark         = '0;
    if (in_body_r) begin
      remain_nxt = remain_r - LEN_W'(1);
      if (remain_r == LEN_W'(1)) begin
        mark.last   = 1'b1;
        in_body_nxt = 1'b0;
        hdr_cnt_nxt = '0;
        acc_nxt     = '0;
        remain_nxt  = '0;
      end
    end else if (hdr_bad) begin
      mark         = '{err: 1'b1, last: 1'b1, start: 1'b1};
      hdr_cnt_nxt  = '0;
      acc_nxt      = '0;
      hex_stop_nxt = 1'b0;
      remain_nxt   = '0;
    end else begin
      mark.start   = (hdr_cnt_r == '0);
      acc_nxt      = acc_upd;
      hex_stop_nxt = hs_upd;
      if (last_hdr) begin
        hdr_cnt_nxt  = '0;
        acc_nxt      = '0;
        hex_stop_nxt = 1'b0;
        remain_nxt   = '0;
        if (len_err) begin
          mark.last = 1'b1;
          mark.err  = 1'b1;
        end else if (len_eq) begin
          mark.last = 1'b1;
        end else begin
          in_body_nxt = 1'b1;
          remain_nxt  = body_len;
        end
      end else begin
        hdr_cnt_nxt = hdr_cnt_r + HDR_LEN_W'(1);
      end
    end
  end

  // Advance framing state on each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r  <= 1'b0;
      hdr_cnt_r  <= '0;
      acc_r      <= '0;
      hex_stop_r <= 1'b0;
      remain_r   <= '0;
    end else if (step_en) begin
      in_body_r  <= in_body_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      acc_r      <= acc_nxt;
      hex_stop_r <= hex_stop_nxt;
      remain_r   <= remain_nxt;
    end
  end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench of the length-prefixed packet deframer.
`timescale 1ns / 1ps
module tb_top import lpd_pkg::*;;

  localparam int CLK_PERIOD  = 10;
  localparam int MAX_HDR     = DEF_MAX_HDR;
  localparam int PIPE_DRAIN  = 4;
  localparam int RANDOM_REQS = 450;
  localparam int CYCLE_LIMIT = 200000;

  // Marks are packed {err, last, start}
  localparam lpd_mark_t MK_NONE    = 3'b000;
  localparam lpd_mark_t MK_START   = 3'b001;
  localparam lpd_mark_t MK_END     = 3'b010;
  localparam lpd_mark_t MK_ERR_END = 3'b110;
  localparam lpd_mark_t MK_ALL     = 3'b111;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    lpd_mark_t         mark;
  } framed_byte_t;

  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [BYTE_W-1:0]     data;
    bit                    fixed;
    lpd_mark_t             mark;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [BYTE_W-1:0]     out_tdata;
  logic                  out_tlast;
  logic [USER_W-1:0]     out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow registers and framing state of the byte predictor
  len_fmt_t             fmt_q;
  logic [HDR_LEN_W-1:0] hdr_len_q;
  logic                 in_payload;
  logic [HDR_LEN_W-1:0] hdr_taken;
  logic [LEN_W-1:0]     len_acc;
  logic                 hex_done;
  logic [LEN_W-1:0]     body_left;

  framed_byte_t expected_bytes[$];
  stim_row_t    directed_rows[$];
  int           mismatches = 0;
  int           items_sent = 0;
  int           cycle_count;
  bit           steady_run = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  length_prefixed_packet_deframer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Drop back to header search
  function automatic void restart_search();
    in_payload = 1'b0;
    hdr_taken  = '0;
    len_acc    = '0;
    hex_done   = 1'b0;
    body_left  = '0;
  endfunction

  // Advance the framing state by one byte and work out its marks
  task automatic deframe_byte(input logic [BYTE_W-1:0] b, output framed_byte_t r);
    int               digit;
    logic [LEN_W-1:0] total;
    r.data = b;
    r.mark = MK_NONE;
    if (in_payload) begin
      body_left = body_left - 1;
      if (body_left == 0) begin
        r.mark.last = 1'b1;
        restart_search();
      end
    end else if (hdr_len_q == 0 || hdr_len_q > MAX_HDR) begin
      r.mark = MK_ALL;
      restart_search();
    end else begin
      if (hdr_taken == 0) begin
        r.mark.start = 1'b1;
        len_acc      = '0;
        hex_done     = 1'b0;
      end
      case (fmt_q)
        FMT_HEX_TOTAL: begin
          if (b >= 8'h30 && b <= 8'h39)      digit = b - 8'h30;
          else if (b >= 8'h61 && b <= 8'h66) digit = b - 8'h61 + 10;
          else if (b >= 8'h41 && b <= 8'h46) digit = b - 8'h41 + 10;
          else                               digit = -1;
          if (hex_done || digit < 0) hex_done = 1'b1;
          else len_acc = {len_acc[LEN_W-5:0], 4'(digit)};
        end
        FMT_LE_PAYLOAD: begin
          if (hdr_taken < LE_MAX_BYTES) len_acc |= 32'(b) << (8 * hdr_taken);
        end
        default: len_acc = {len_acc[LEN_W-9:0], b};
      endcase
      if (hdr_taken + 1 >= hdr_len_q) begin
        // Header done: resolve the total packet length
        if (fmt_q == FMT_HEX_TOTAL)                 total = len_acc;
        else if (hdr_len_q != 2 && hdr_len_q != 4)  total = '0;
        else if (fmt_q == FMT_BIN_TOTAL)            total = len_acc;
        else                                        total = len_acc + LEN_W'(hdr_len_q);
        restart_search();
        if (total < hdr_len_q) begin
          r.mark.last = 1'b1;
          r.mark.err  = 1'b1;
        end else if (total == hdr_len_q) begin
          r.mark.last = 1'b1;
        end else begin
          in_payload = 1'b1;
          body_left  = total - LEN_W'(hdr_len_q);
        end
      end else begin
        hdr_taken = hdr_taken + HDR_LEN_W'(1);
      end
    end
  endtask

  // Offer one byte on the input stream and record its expected result
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit fixed,
                           input lpd_mark_t mark);
    framed_byte_t want;
    @(negedge clk);
    while (!steady_run && $urandom_range(99) < 11) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    deframe_byte(b, want);
    if (fixed) want.mark = mark;
    expected_bytes.push_back(want);
    items_sent++;
    steady_run = (items_sent >= 200 && items_sent < 300);
  endtask

  // Drain the pipeline, then write one register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_LENGTH_FORMAT) fmt_q = len_fmt_t'(val[FMT_W-1:0]);
    else hdr_len_q = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Send one length header under the live format; broken ones decode to a total no longer than the header, or overflow
  task automatic send_header(input bit broken);
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] c;
    logic [3:0]        nib;
    int                body;
    int                digits;
    int                lead;
    body = ($urandom_range(99) < 90) ? $urandom_range(12, 1) : $urandom_range(40, 13);
    if (fmt_q == FMT_HEX_TOTAL) begin
      if (broken) len = $urandom_range(hdr_len_q, 0);
      else len = hdr_len_q + body;
      if (hdr_len_q == 1 && len > 15) len = 15;
      digits = (len > 15) ? 2 : 1;
      if (broken && $urandom_range(3) == 0) digits = 0;
      lead = $urandom_range(hdr_len_q - digits, 0);
      // Leading zeros, digits, one stop character, then anything
      for (int i = 0; i < hdr_len_q; i++) begin
        if (i < lead) begin
          c = "0";
        end else if (i < lead + digits) begin
          nib = 4'(len >> (4 * (lead + digits - 1 - i)));
          if (nib < 10) c = 8'h30 + nib;
          else c = 8'(($urandom_range(1) ? 8'h41 : 8'h61) + nib - 10);
        end else if (i == lead + digits) begin
          do c = 8'($urandom);
          while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                 (c >= 8'h61 && c <= 8'h66));
        end else begin
          c = 8'($urandom);
        end
        send_byte(c, 1'b0, MK_NONE);
      end
    end else begin
      if (!broken) len = (fmt_q == FMT_BIN_TOTAL) ? hdr_len_q + body : body;
      else if (fmt_q == FMT_BIN_TOTAL) len = $urandom_range(hdr_len_q, 0);
      else if (hdr_len_q == 4 && $urandom_range(1)) len = 32'hFFFF_FFFF - $urandom_range(3, 0);
      else len = '0;
      for (int i = 0; i < hdr_len_q; i++) begin
        if (fmt_q == FMT_LE_PAYLOAD) c = 8'(len >> (8 * i));
        else c = 8'(len >> (8 * (hdr_len_q - 1 - i)));
        send_byte(c, 1'b0, MK_NONE);
      end
    end
  endtask

  task automatic add_byte(input logic [BYTE_W-1:0] data, input bit fixed, input lpd_mark_t mark);
    stim_row_t row;
    row          = '{default: '0};
    row.data     = data;
    row.fixed    = fixed;
    row.mark     = mark;
    directed_rows.push_back(row);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row          = '{default: '0};
    row.is_write = 1'b1;
    row.idx      = idx;
    row.val      = val;
    directed_rows.push_back(row);
  endtask

  // Randomly stall the result stream
  initial out_tready = 1'b1;
  always @(negedge clk) out_tready = steady_run || ($urandom_range(99) >= 11);

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    framed_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte %02h start %b end %b err %b",
                   out_tdata, out_tuser[0], out_tlast, out_tuser[1]);
      end else begin
        want = expected_bytes.pop_front();
        if (out_tdata !== want.data || out_tuser[0] !== want.mark.start ||
            out_tlast !== want.mark.last || out_tuser[1] !== want.mark.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %02h s%b e%b x%b, got %02h s%b e%b x%b",
                     want.data, want.mark.start, want.mark.last, want.mark.err,
                     out_tdata, out_tuser[0], out_tlast, out_tuser[1]);
        end
      end
    end
  end

  // Bound the run
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    len_fmt_t             fmt;
    logic [HDR_LEN_W-1:0] hdr;
    int                   random_goal;
    int                   phase_end;
    int                   phase;
    bit                   cut;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    fmt_q     = FMT_BIN_TOTAL;
    hdr_len_q = HDR_BYTES_RST;
    restart_search();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset defaults: binary total, two-byte header; total 3 leaves one body byte
    add_byte(8'h00, 1'b1, MK_START);
    add_byte(8'h03, 1'b1, MK_NONE);
    add_byte(8'hFF, 1'b1, MK_END);
    // Zero length
    add_byte(8'h00, 1'b1, MK_START);
    add_byte(8'h00, 1'b1, MK_ERR_END);
    // Hex text: digit then stop character, total equals the header
    add_write(REG_LENGTH_FORMAT, CFG_DATA_W'(FMT_HEX_TOTAL));
    add_write(REG_HEADER_BYTES, 4'd2);
    add_byte("2", 1'b0, MK_NONE);
    add_byte("g", 1'b0, MK_NONE);
    // Hex text without digits decodes to zero; digits after the stop are ignored
    add_byte("Z", 1'b1, MK_START);
    add_byte("5", 1'b1, MK_ERR_END);
    // Little-endian payload of one byte
    add_write(REG_LENGTH_FORMAT, CFG_DATA_W'(FMT_LE_PAYLOAD));
    add_write(REG_HEADER_BYTES, 4'd4);
    add_byte(8'h01, 1'b0, MK_NONE);
    add_byte(8'h00, 1'b0, MK_NONE);
    add_byte(8'h00, 1'b0, MK_NONE);
    add_byte(8'h00, 1'b0, MK_NONE);
    add_byte(8'hA5, 1'b0, MK_NONE);
    // Big-endian payload that overflows into a short total
    add_write(REG_LENGTH_FORMAT, CFG_DATA_W'(FMT_BE_PAYLOAD));
    add_byte(8'hFF, 1'b1, MK_START);
    add_byte(8'hFF, 1'b1, MK_NONE);
    add_byte(8'hFF, 1'b1, MK_NONE);
    add_byte(8'hFF, 1'b1, MK_ERR_END);
    // Shrink the header while one is half taken
    add_write(REG_LENGTH_FORMAT, CFG_DATA_W'(FMT_BIN_TOTAL));
    add_byte(8'h00, 1'b0, MK_NONE);
    add_byte(8'h00, 1'b0, MK_NONE);
    add_write(REG_HEADER_BYTES, 4'd2);
    add_byte(8'h03, 1'b0, MK_NONE);
    add_byte(8'h7E, 1'b0, MK_NONE);
    // Binary header of a length the binary formats reject
    add_write(REG_HEADER_BYTES, 4'd3);
    add_byte(8'h00, 1'b1, MK_START);
    add_byte(8'h12, 1'b1, MK_NONE);
    add_byte(8'h34, 1'b1, MK_ERR_END);
    // Header length beyond the maximum
    add_write(REG_HEADER_BYTES, 4'd15);
    add_byte(8'hC3, 1'b1, MK_ALL);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) write_reg(directed_rows[i].idx, directed_rows[i].val);
      else send_byte(directed_rows[i].data, directed_rows[i].fixed, directed_rows[i].mark);
    end

    // Random phases, each under its own register setting
    random_goal = items_sent + RANDOM_REQS;
    phase = 0;
    while (items_sent < random_goal) begin
      case (phase)
        0: begin fmt = FMT_HEX_TOTAL;  hdr = 4'd1;  end
        1: begin fmt = FMT_HEX_TOTAL;  hdr = 4'd8;  end
        2: begin fmt = FMT_LE_PAYLOAD; hdr = 4'd4;  end
        3: begin fmt = FMT_BE_PAYLOAD; hdr = 4'd2;  end
        4: begin fmt = FMT_BIN_TOTAL;  hdr = 4'd4;  end
        5: begin fmt = FMT_BIN_TOTAL;  hdr = 4'd0;  end
        6: begin fmt = FMT_LE_PAYLOAD; hdr = 4'd15; end
        7: begin fmt = FMT_BE_PAYLOAD; hdr = 4'd7;  end
        default: begin
          fmt = len_fmt_t'($urandom_range(3));
          if ($urandom_range(3) == 0) hdr = 4'($urandom_range(15));
          else if (fmt == FMT_HEX_TOTAL) hdr = 4'($urandom_range(MAX_HDR, 1));
          else hdr = $urandom_range(1) ? 4'd2 : 4'd4;
        end
      endcase
      phase++;
      write_reg(REG_LENGTH_FORMAT, {2'($urandom), fmt});
      write_reg(REG_HEADER_BYTES, hdr);
      // Finish a body cut off by the last phase
      while (in_payload) send_byte(8'($urandom), 1'b0, MK_NONE);
      phase_end = items_sent + $urandom_range(60, 30);
      if (hdr >= 1 && hdr <= MAX_HDR &&
          (fmt == FMT_HEX_TOTAL || hdr == 2 || hdr == 4)) begin
        while (items_sent < phase_end) begin
          send_header($urandom_range(3) == 0);
          cut = ($urandom_range(9) == 0);
          while (in_payload && !(cut && $urandom_range(3) == 0))
            send_byte(8'($urandom), 1'b0, MK_NONE);
          if (in_payload) break;
        end
      end else if (hdr >= 1 && hdr <= MAX_HDR) begin
        // Rejected binary header length: whole headers of noise
        repeat ($urandom_range(5, 2) * hdr) send_byte(8'($urandom), 1'b0, MK_NONE);
      end else begin
        repeat ($urandom_range(8, 3)) send_byte(8'($urandom), 1'b0, MK_NONE);
      end
    end

    // Drain and report
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: length_prefixed_packet_deframer_top.f
hdl/lpd_pkg.sv
hdl/lpd_framer.sv
hdl/length_prefixed_packet_deframer_top.sv
tb/tb_top.sv
